FILE: rtl/core/mseu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mseu_pkg
// Shared constants for the MIPS subset execute unit: opcodes, function codes,
// action codes, error codes, sizes and per-class stage cycle values.
// ----------------------------------------------------------------------------
package mseu_pkg;

    localparam int unsigned MEM_WORDS_DEFAULT = 256;
    localparam int unsigned REG_COUNT = 32;
    localparam int unsigned RF_AW = $clog2(REG_COUNT);

    localparam logic [5:0] OP_RTYPE = 6'b000000;
    localparam logic [5:0] OP_BEQ = 6'b000100;
    localparam logic [5:0] OP_BNE = 6'b000101;
    localparam logic [5:0] OP_ADDI = 6'b001000;
    localparam logic [5:0] OP_LW = 6'b100011;
    localparam logic [5:0] OP_SW = 6'b101011;

    localparam logic [5:0] FN_ADD = 6'b100000;
    localparam logic [5:0] FN_SUB = 6'b100010;
    localparam logic [5:0] FN_SLT = 6'b101010;

    localparam logic [2:0] ACT_EXEC = 3'd0;
    localparam logic [2:0] ACT_WR_REG = 3'd1;
    localparam logic [2:0] ACT_WR_MEM = 3'd2;
    localparam logic [2:0] ACT_RD_REG = 3'd3;
    localparam logic [2:0] ACT_RD_MEM = 3'd4;

    localparam logic [1:0] ERR_OK = 2'd0;
    localparam logic [1:0] ERR_UNSUP = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;

    localparam logic [2:0] CYC_LW = 3'd5;
    localparam logic [2:0] CYC_SW = 3'd4;
    localparam logic [2:0] CYC_ALU = 3'd4;
    localparam logic [2:0] CYC_BRANCH = 3'd3;

endpackage
`default_nettype wire

FILE: rtl/core/mips_subset_execute_unit.sv
`default_nettype none
// Pipeline: an item is registered into stage s1, then its result into stage s2.
// Throughput: one item per cycle, set by the single write port of the register
// file and the single port of the data memory; result_stall holds the pipe.
// Reset: control state clears at once; the data memory is then cleared one
// word per cycle, from word 0 to word MEM_WORDS-1, while item_stall stays high.
// ----------------------------------------------------------------------------
// mips_subset_execute_unit
// Executes ADD, SUB, SLT, ADDI, LW, SW, BEQ, BNE and register/memory accesses
// on a register file and a word memory; forwards from write-back and last write.
// ----------------------------------------------------------------------------
module mips_subset_execute_unit #(
    parameter int unsigned MEM_WORDS = mseu_pkg::MEM_WORDS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic [2:0]         action,
    input  wire logic [31:0]        instruction,
    input  wire logic [7:0]         index,
    input  wire logic signed [31:0] value,
    input  wire logic               squash,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic signed [31:0]      read_value,
    output logic                    branch_taken,
    output logic signed [15:0]      branch_offset,
    output logic [2:0]              stage_cycles,
    output logic [31:0]             instructions_total,
    output logic [31:0]             cycles_total,
    output logic [1:0]              error_code
);
    import mseu_pkg::*;

    localparam int unsigned MEM_AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    logic [31:0]       rf_mem [REG_COUNT];
    logic [31:0]       dmem [MEM_WORDS];
    logic [REG_COUNT-1:0] rf_valid_reg;

    logic              clr_active_reg;
    logic [MEM_AW-1:0] clr_addr_reg;

    logic              s1_valid_reg;
    logic [2:0]        s1_action_reg;
    logic [31:0]       s1_instr_reg;
    logic [7:0]        s1_index_reg;
    logic [31:0]       s1_value_reg;
    logic              s1_squash_reg;
    logic [RF_AW-1:0]  s1_addr_a_reg;
    logic [RF_AW-1:0]  s1_addr_b_reg;
    logic              s1_vld_a_reg;
    logic              s1_vld_b_reg;
    logic [31:0]       rf_qa_reg;
    logic [31:0]       rf_qb_reg;

    logic              s2_valid_reg;
    logic              s2_read_mem_reg;
    logic [31:0]       s2_read_value_reg;
    logic              s2_taken_reg;
    logic [15:0]       s2_offset_reg;
    logic [2:0]        s2_cycles_reg;
    logic [1:0]        s2_err_reg;
    logic [31:0]       s2_retired_reg;
    logic [31:0]       s2_cycle_cnt_reg;
    logic              s2_wb_en_reg;
    logic              s2_wb_load_reg;
    logic [RF_AW-1:0]  s2_wb_addr_reg;
    logic [31:0]       s2_wb_data_reg;
    logic [31:0]       mem_q_reg;

    logic [31:0]       retired_reg;
    logic [31:0]       cycle_cnt_reg;
    logic [31:0]       retired_next;
    logic [31:0]       cycle_cnt_next;

    logic              last_vld_reg;
    logic [RF_AW-1:0]  last_addr_reg;
    logic [31:0]       last_data_reg;

    logic              item_fire;
    logic              s1_adv;
    logic              s2_leave;
    logic [RF_AW-1:0]  rd_addr_a;
    logic [RF_AW-1:0]  rd_addr_b;
    logic [31:0]       wb_value;

    logic [5:0]        op;
    logic [5:0]        fn;
    logic [RF_AW-1:0]  rt;
    logic [RF_AW-1:0]  rd;
    logic [15:0]       imm;
    logic [31:0]       simm;
    logic [31:0]       opa;
    logic [31:0]       opb;
    logic [31:0]       sum_addr;
    logic              addr_ok;
    logic [31:0]       idx_wide;
    logic              idx_ok;

    logic [2:0]        cyc;
    logic [1:0]        err;
    logic              taken;
    logic [15:0]       offset;
    logic [31:0]       rdv;
    logic              mem_rd;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_addr;
    logic [31:0]       mem_wdata;
    logic              wb_en;
    logic              wb_load;
    logic [RF_AW-1:0]  wb_addr;
    logic [31:0]       wb_data;

    function automatic logic [31:0] fwd_sel(
        input logic [RF_AW-1:0] addr,
        input logic [31:0]      q,
        input logic             vld
    );
        logic [31:0] res;
        if (s2_valid_reg && s2_wb_en_reg && (s2_wb_addr_reg == addr)) begin
            res = wb_value;
        end else if (last_vld_reg && (last_addr_reg == addr)) begin
            res = last_data_reg;
        end else begin
            res = vld ? q : '0;
        end
        return res;
    endfunction

    assign s2_leave = s2_valid_reg && !result_stall;
    assign s1_adv = s1_valid_reg && (!s2_valid_reg || !result_stall);
    assign item_stall = clr_active_reg || (s1_valid_reg && !s1_adv);
    assign item_fire = item_valid && !item_stall;

    assign rd_addr_a = (action == ACT_RD_REG) ? index[RF_AW-1:0] : instruction[25:21];
    assign rd_addr_b = instruction[20:16];
    assign wb_value = s2_wb_load_reg ? mem_q_reg : s2_wb_data_reg;

    assign op = s1_instr_reg[31:26];
    assign fn = s1_instr_reg[5:0];
    assign rt = s1_instr_reg[20:16];
    assign rd = s1_instr_reg[15:11];
    assign imm = s1_instr_reg[15:0];
    assign simm = {{16{imm[15]}}, imm};

    always_comb
    begin
        opa = fwd_sel(s1_addr_a_reg, rf_qa_reg, s1_vld_a_reg);
        opb = fwd_sel(s1_addr_b_reg, rf_qb_reg, s1_vld_b_reg);
    end

    assign sum_addr = opa + simm;
    assign addr_ok = !sum_addr[31] && ({2'b00, sum_addr[31:2]} < 32'(MEM_WORDS));
    assign idx_wide = 32'(s1_index_reg);
    assign idx_ok = idx_wide < 32'(MEM_WORDS);

    always_comb
    begin
        cyc = '0;
        err = ERR_OK;
        taken = 1'b0;
        offset = '0;
        rdv = '0;
        mem_rd = 1'b0;
        mem_we = 1'b0;
        mem_addr = idx_wide[MEM_AW-1:0];
        mem_wdata = s1_value_reg;
        wb_en = 1'b0;
        wb_load = 1'b0;
        wb_addr = rd;
        wb_data = '0;
        unique case (s1_action_reg)
            ACT_EXEC:
            begin
                if (!s1_squash_reg) begin
                    case (op)
                        OP_RTYPE:
                        begin
                            case (fn)
                                FN_ADD:
                                begin
                                    wb_en = 1'b1;
                                    wb_data = opa + opb;
                                    cyc = CYC_ALU;
                                end
                                FN_SUB:
                                begin
                                    wb_en = 1'b1;
                                    wb_data = opa - opb;
                                    cyc = CYC_ALU;
                                end
                                FN_SLT:
                                begin
                                    wb_en = 1'b1;
                                    wb_data = {31'd0, $signed(opa) < $signed(opb)};
                                    cyc = CYC_ALU;
                                end
                                default:
                                begin
                                    err = ERR_UNSUP;
                                end
                            endcase
                        end
                        OP_ADDI:
                        begin
                            wb_en = 1'b1;
                            wb_addr = rt;
                            wb_data = sum_addr;
                            cyc = CYC_ALU;
                        end
                        OP_LW:
                        begin
                            mem_addr = sum_addr[MEM_AW+1:2];
                            if (addr_ok) begin
                                mem_rd = 1'b1;
                                wb_en = 1'b1;
                                wb_load = 1'b1;
                                wb_addr = rt;
                                cyc = CYC_LW;
                            end else begin
                                err = ERR_RANGE;
                            end
                        end
                        OP_SW:
                        begin
                            mem_addr = sum_addr[MEM_AW+1:2];
                            mem_wdata = opb;
                            if (addr_ok) begin
                                mem_we = 1'b1;
                                cyc = CYC_SW;
                            end else begin
                                err = ERR_RANGE;
                            end
                        end
                        OP_BEQ, OP_BNE:
                        begin
                            taken = ((opa == opb) == (op == OP_BEQ));
                            offset = taken ? imm : '0;
                            cyc = CYC_BRANCH;
                        end
                        default:
                        begin
                            err = ERR_UNSUP;
                        end
                    endcase
                end
            end
            ACT_WR_REG:
            begin
                wb_en = 1'b1;
                wb_addr = s1_index_reg[RF_AW-1:0];
                wb_data = s1_value_reg;
            end
            ACT_WR_MEM:
            begin
                if (idx_ok) begin
                    mem_we = 1'b1;
                end else begin
                    err = ERR_RANGE;
                end
            end
            ACT_RD_REG:
            begin
                rdv = opa;
            end
            ACT_RD_MEM:
            begin
                if (idx_ok) begin
                    mem_rd = 1'b1;
                end else begin
                    err = ERR_RANGE;
                end
            end
            default:
            begin
                err = ERR_UNSUP;
            end
        endcase
    end

    assign retired_next = retired_reg + ((cyc != '0) ? 32'd1 : 32'd0);
    assign cycle_cnt_next = cycle_cnt_reg + 32'(cyc);

    always_ff @(posedge clk)
    begin
        if (item_fire) begin
            rf_qa_reg <= rf_mem[rd_addr_a];
            rf_qb_reg <= rf_mem[rd_addr_b];
        end
        if (s2_leave && s2_wb_en_reg) begin
            rf_mem[s2_wb_addr_reg] <= wb_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg) begin
            dmem[clr_addr_reg] <= '0;
        end else if (s1_adv && mem_we) begin
            dmem[mem_addr] <= mem_wdata;
        end
        if (s1_adv && mem_rd) begin
            mem_q_reg <= dmem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire) begin
            s1_action_reg <= action;
            s1_instr_reg <= instruction;
            s1_index_reg <= index;
            s1_value_reg <= value;
            s1_squash_reg <= squash;
            s1_addr_a_reg <= rd_addr_a;
            s1_addr_b_reg <= rd_addr_b;
            s1_vld_a_reg <= rf_valid_reg[rd_addr_a];
            s1_vld_b_reg <= rf_valid_reg[rd_addr_b];
        end
        if (s1_adv) begin
            s2_read_mem_reg <= mem_rd && (s1_action_reg == ACT_RD_MEM);
            s2_read_value_reg <= rdv;
            s2_taken_reg <= taken;
            s2_offset_reg <= offset;
            s2_cycles_reg <= cyc;
            s2_err_reg <= err;
            s2_retired_reg <= retired_next;
            s2_cycle_cnt_reg <= cycle_cnt_next;
            s2_wb_en_reg <= wb_en;
            s2_wb_load_reg <= wb_load;
            s2_wb_addr_reg <= wb_addr;
            s2_wb_data_reg <= wb_data;
        end
        if (s2_leave && s2_wb_en_reg) begin
            last_addr_reg <= s2_wb_addr_reg;
            last_data_reg <= wb_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            retired_reg <= 32'd1;
            cycle_cnt_reg <= 32'd1;
            last_vld_reg <= 1'b0;
            rf_valid_reg <= '0;
        end else begin
            if (clr_active_reg) begin
                if (clr_addr_reg == MEM_AW'(MEM_WORDS - 1)) begin
                    clr_active_reg <= 1'b0;
                end else begin
                    clr_addr_reg <= clr_addr_reg + MEM_AW'(1);
                end
            end
            if (item_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                s2_valid_reg <= 1'b1;
                retired_reg <= retired_next;
                cycle_cnt_reg <= cycle_cnt_next;
            end else if (s2_leave) begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_leave && s2_wb_en_reg) begin
                last_vld_reg <= 1'b1;
                rf_valid_reg[s2_wb_addr_reg] <= 1'b1;
            end
        end
    end

    assign result_valid = s2_valid_reg;
    assign read_value = s2_read_mem_reg ? mem_q_reg : s2_read_value_reg;
    assign branch_taken = s2_taken_reg;
    assign branch_offset = s2_offset_reg;
    assign stage_cycles = s2_cycles_reg;
    assign instructions_total = s2_retired_reg;
    assign cycles_total = s2_cycle_cnt_reg;
    assign error_code = s2_err_reg;

endmodule
`default_nettype wire

FILE: bench/mips_subset_execute_unit_test.sv
// ----------------------------------------------------------------------------
// MIPS subset execute unit testbench
// Sends register and memory preloads, reads and MIPS subset instructions to
// the execute unit and compares every result with a fixed table outcome or
// an in-bench model of the register file, memory and counts. A directed table
// comes first, then constrained-by-hand random items in four idling phases.
// ----------------------------------------------------------------------------
module mips_subset_execute_unit_test;
    import mseu_pkg::*;

    localparam int unsigned MEM_WORDS = MEM_WORDS_DEFAULT;
    localparam int RANDOM_ITEMS = 600;
    localparam int PHASE_ITEMS = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT = 300000;

    localparam logic [2:0] ACT_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] ACT_LAST_CODE = 3'd7;
    localparam logic [5:0] OP_UNUSED = 6'b111111;
    localparam logic [5:0] FN_UNUSED = 6'b100001;
    localparam logic [31:0] SHAMT_MASK = 32'h0000_07C0;

    typedef struct packed {
        logic [2:0]         action;
        logic [31:0]        instruction;
        logic [7:0]         index;
        logic signed [31:0] value;
        logic               squash;
    } item_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               branch_taken;
        logic signed [15:0] branch_offset;
        logic [2:0]         stage_cycles;
        logic [31:0]        instructions_total;
        logic [31:0]        cycles_total;
        logic [1:0]         error_code;
    } outcome_t;

    typedef struct packed {
        item_t    stim;
        logic     fixed;
        outcome_t want;
    } vector_t;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic [2:0]         action;
    logic [31:0]        instruction;
    logic [7:0]         index;
    logic signed [31:0] value;
    logic               squash;
    logic               result_valid;
    logic               result_stall;
    logic signed [31:0] read_value;
    logic               branch_taken;
    logic signed [15:0] branch_offset;
    logic [2:0]         stage_cycles;
    logic [31:0]        instructions_total;
    logic [31:0]        cycles_total;
    logic [1:0]         error_code;

    logic [31:0] arch_regs [REG_COUNT];
    logic [31:0] data_words [MEM_WORDS];
    logic [31:0] retired;
    logic [31:0] cycle_sum;

    outcome_t pending_outcomes [$];
    vector_t  directed [$];
    int       errors = 0;
    int       tick_total = 0;
    int       send_idle_pct = 0;
    int       stall_pct = 0;

    mips_subset_execute_unit #(
        .MEM_WORDS(MEM_WORDS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .action(action),
        .instruction(instruction),
        .index(index),
        .value(value),
        .squash(squash),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .read_value(read_value),
        .branch_taken(branch_taken),
        .branch_offset(branch_offset),
        .stage_cycles(stage_cycles),
        .instructions_total(instructions_total),
        .cycles_total(cycles_total),
        .error_code(error_code)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [31:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
                                          input logic [4:0] rd, input logic [5:0] fn);
        return {OP_RTYPE, rs, rt, rd, 5'd0, fn};
    endfunction

    function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic item_t mk_item(input logic [2:0] act, input logic [31:0] instr,
                                      input logic [7:0] idx, input logic [31:0] val,
                                      input logic sq);
        item_t it;
        it.action = act;
        it.instruction = instr;
        it.index = idx;
        it.value = val;
        it.squash = sq;
        return it;
    endfunction

    function automatic outcome_t reset_outcome(input logic [1:0] err);
        outcome_t o;
        o = '0;
        o.instructions_total = 32'd1;
        o.cycles_total = 32'd1;
        o.error_code = err;
        return o;
    endfunction

    function automatic void add_row(input vector_t row);
        directed.insert(directed.size(), row);
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 7))
            0, 1: return $urandom_range(0, 16) - 32'd8;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic word_in_range(input logic [31:0] addr);
        return !addr[31] && ((addr >> 2) < MEM_WORDS);
    endfunction

    function automatic outcome_t execute_item(input item_t it);
        outcome_t    o;
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] simm;
        logic [31:0] addr;
        o = '0;
        case (it.action)
            ACT_EXEC:
            begin
                if (!it.squash)
                begin
                    op = it.instruction[31:26];
                    rs = it.instruction[25:21];
                    rt = it.instruction[20:16];
                    rd = it.instruction[15:11];
                    fn = it.instruction[5:0];
                    a = arch_regs[rs];
                    b = arch_regs[rt];
                    simm = {{16{it.instruction[15]}}, it.instruction[15:0]};
                    addr = a + simm;
                    case (op)
                        OP_RTYPE:
                        begin
                            case (fn)
                                FN_ADD:
                                begin
                                    arch_regs[rd] = a + b;
                                    o.stage_cycles = CYC_ALU;
                                end
                                FN_SUB:
                                begin
                                    arch_regs[rd] = a - b;
                                    o.stage_cycles = CYC_ALU;
                                end
                                FN_SLT:
                                begin
                                    arch_regs[rd] = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                                    o.stage_cycles = CYC_ALU;
                                end
                                default: o.error_code = ERR_UNSUP;
                            endcase
                        end
                        OP_ADDI:
                        begin
                            arch_regs[rt] = a + simm;
                            o.stage_cycles = CYC_ALU;
                        end
                        OP_LW:
                        begin
                            if (word_in_range(addr))
                            begin
                                arch_regs[rt] = data_words[addr >> 2];
                                o.stage_cycles = CYC_LW;
                            end
                            else
                            begin
                                o.error_code = ERR_RANGE;
                            end
                        end
                        OP_SW:
                        begin
                            if (word_in_range(addr))
                            begin
                                data_words[addr >> 2] = b;
                                o.stage_cycles = CYC_SW;
                            end
                            else
                            begin
                                o.error_code = ERR_RANGE;
                            end
                        end
                        OP_BEQ, OP_BNE:
                        begin
                            o.branch_taken = ((a == b) == (op == OP_BEQ));
                            o.branch_offset = o.branch_taken ? it.instruction[15:0] : 16'd0;
                            o.stage_cycles = CYC_BRANCH;
                        end
                        default: o.error_code = ERR_UNSUP;
                    endcase
                    if (o.stage_cycles != 3'd0)
                    begin
                        retired = retired + 32'd1;
                        cycle_sum = cycle_sum + 32'(o.stage_cycles);
                    end
                end
            end
            ACT_WR_REG: arch_regs[it.index[4:0]] = it.value;
            ACT_WR_MEM:
            begin
                if (it.index < MEM_WORDS)
                    data_words[it.index] = it.value;
                else
                    o.error_code = ERR_RANGE;
            end
            ACT_RD_REG: o.read_value = arch_regs[it.index[4:0]];
            ACT_RD_MEM:
            begin
                if (it.index < MEM_WORDS)
                    o.read_value = data_words[it.index];
                else
                    o.error_code = ERR_RANGE;
            end
            default: o.error_code = ERR_UNSUP;
        endcase
        o.instructions_total = retired;
        o.cycles_total = cycle_sum;
        return o;
    endfunction

    task automatic send_item(input item_t it, input logic fixed, input outcome_t fixed_want);
        outcome_t model_out;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        action <= it.action;
        instruction <= it.instruction;
        index <= it.index;
        value <= it.value;
        squash <= it.squash;
        do
            @(posedge clk);
        while (item_stall);
        model_out = execute_item(it);
        pending_outcomes.insert(pending_outcomes.size(), fixed ? fixed_want : model_out);
    endtask

    task automatic wait_for_results();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_outcomes.size() != 0);
    endtask

    task automatic send_memory_op(input logic [5:0] op, input logic [4:0] rs,
                                  input logic [4:0] rt, input logic sq);
        longint      target;
        longint      offset;
        logic [31:0] base;
        case ($urandom_range(0, 15))
            0: target = -longint'($urandom_range(1, 64));
            1: target = longint'(MEM_WORDS) * 4 + longint'($urandom_range(0, 64));
            default: target = longint'($urandom_range(0, MEM_WORDS - 1)) * 4
                              + longint'($urandom_range(0, 3));
        endcase
        offset = target - longint'($signed(arch_regs[rs]));
        if (offset < -32768 || offset > 32767)
        begin
            base = $urandom_range(0, 1023);
            send_item(mk_item(ACT_WR_REG, $urandom, {3'($urandom), rs}, base, 1'($urandom)),
                      1'b0, '0);
            offset = target - longint'(base);
        end
        send_item(mk_item(ACT_EXEC, enc_i(op, rs, rt, offset[15:0]), 8'($urandom),
                          $urandom, sq), 1'b0, '0);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: result transfer with no expectation pending", $time);
                errors++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                compare_field("read_value", want.read_value, read_value);
                compare_field("branch_taken", 32'(want.branch_taken), 32'(branch_taken));
                compare_field("branch_offset", 32'(want.branch_offset), 32'(branch_offset));
                compare_field("stage_cycles", 32'(want.stage_cycles), 32'(stage_cycles));
                compare_field("instructions_total", want.instructions_total,
                              instructions_total);
                compare_field("cycles_total", want.cycles_total, cycles_total);
                compare_field("error_code", 32'(want.error_code), 32'(error_code));
            end
        end
        result_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        tick_total <= tick_total + 1;
        if (tick_total >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        item_t      it;
        int         sel;
        logic [4:0] rs;
        logic [4:0] rt;
        logic [4:0] rd;
        logic [5:0] op;
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        action <= ACT_EXEC;
        instruction <= '0;
        index <= '0;
        value <= '0;
        squash <= 1'b0;
        result_stall <= 1'b0;
        foreach (arch_regs[i])
            arch_regs[i] = '0;
        foreach (data_words[i])
            data_words[i] = '0;
        retired = 32'd1;
        cycle_sum = 32'd1;

        add_row('{mk_item(ACT_RD_REG, '0, 8'd5, '0, 1'b0), 1'b1,
                  reset_outcome(ERR_OK)});
        add_row('{mk_item(ACT_RD_MEM, '0, 8'd255, '0, 1'b0), 1'b1,
                  reset_outcome(ERR_OK)});
        add_row('{mk_item(ACT_LAST_CODE, '0, 8'd0, '0, 1'b0), 1'b1,
                  reset_outcome(ERR_UNSUP)});
        add_row('{mk_item(ACT_EXEC, enc_i(OP_UNUSED, 5'd0, 5'd0, 16'h0), 8'd0, '0,
                          1'b0), 1'b1, reset_outcome(ERR_UNSUP)});
        add_row('{mk_item(ACT_EXEC, enc_i(OP_ADDI, 5'd0, 5'd1, 16'd5), 8'd0, '0,
                          1'b1), 1'b1, reset_outcome(ERR_OK)});
        add_row('{mk_item(ACT_EXEC, enc_i(OP_LW, 5'd0, 5'd1, 16'hFFFC), 8'd0, '0,
                          1'b0), 1'b1, reset_outcome(ERR_RANGE)});
        add_row('{mk_item(ACT_EXEC, enc_i(OP_SW, 5'd0, 5'd1, 16'h0400), 8'd0, '0,
                          1'b0), 1'b1, reset_outcome(ERR_RANGE)});
        add_row('{mk_item(ACT_EXEC, enc_r(5'd0, 5'd0, 5'd1, FN_UNUSED), 8'd0, '0,
                          1'b0), 1'b1, reset_outcome(ERR_UNSUP)});
        add_row('{mk_item(ACT_WR_REG, '0, 8'hFF, 32'h7FFF_FFFF, 1'b1), 1'b1,
                  reset_outcome(ERR_OK)});
        add_row('{mk_item(ACT_RD_REG, '0, 8'h1F, '0, 1'b0), 1'b0, '0});
        add_row('{mk_item(ACT_WR_REG, '0, 8'd1, 32'h8000_0000, 1'b0), 1'b0, '0});
        add_row('{mk_item(ACT_WR_REG, '0, 8'd2, 32'hFFFF_FFFF, 1'b0), 1'b0, '0});
        add_row('{mk_item(ACT_EXEC, enc_r(5'd1, 5'd2, 5'd3, FN_ADD) | SHAMT_MASK,
                          8'd0, '0, 1'b0), 1'b0, '0});
        add_row('{mk_item(ACT_EXEC, enc_r(5'd1, 5'd31, 5'd4, FN_SUB), 8'd0, '0,
                          1'b0), 1'b0, '0});
        add_row('{mk_item(ACT_EXEC, enc_r(5'd1, 5'd2, 5'd5, FN_SLT), 8'd0, '0,
                          1'b0), 1'b0, '0});
        add_row('{mk_item(ACT_EXEC, enc_r(5'd31, 5'd1, 5'd6, FN_SLT), 8'd0, '0,
                          1'b0), 1'b0, '0});
        add_row('{mk_item(ACT_EXEC, enc_i(OP_ADDI, 5'd2, 5'd0, 16'h7FFF), 8'd0, '0,
                          1'b0), 1'b0, '0});
        add_row('{mk_item(ACT_EXEC, enc_i(OP_ADDI, 5'd0, 5'd7, 16'h8000), 8'd0, '0,
                          1'b0), 1'b0, '0});
        add_row('{mk_item(ACT_EXEC, enc_i(OP_SW, 5'd0, 5'd1, 16'h8401), 8'd0, '0,
                          1'b0), 1'b0, '0});
        add_row('{mk_item(ACT_EXEC, enc_i(OP_LW, 5'd0, 5'd8, 16'h8401), 8'd0, '0,
                          1'b0), 1'b0, '0});
        add_row('{mk_item(ACT_RD_MEM, '0, 8'd255, '0, 1'b0), 1'b0, '0});
        add_row('{mk_item(ACT_EXEC, enc_i(OP_BEQ, 5'd1, 5'd8, 16'h8000), 8'd0, '0,
                          1'b0), 1'b0, '0});
        add_row('{mk_item(ACT_EXEC, enc_i(OP_BNE, 5'd1, 5'd2, 16'h7FFF), 8'd0, '0,
                          1'b0), 1'b0, '0});
        add_row('{mk_item(ACT_EXEC, enc_i(OP_BEQ, 5'd1, 5'd2, 16'h1234), 8'd0, '0,
                          1'b0), 1'b0, '0});
        add_row('{mk_item(ACT_EXEC, enc_i(OP_BNE, 5'd3, 5'd3, 16'hFFFF), 8'd0, '0,
                          1'b0), 1'b0, '0});
        add_row('{mk_item(ACT_RD_REG, '0, 8'hE0, '0, 1'b0), 1'b0, '0});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_item(directed[i].stim, directed[i].fixed, directed[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_ITEMS == 0)
            begin
                case (n / PHASE_ITEMS)
                    0:
                    begin
                        send_idle_pct = 0;
                        stall_pct = 0;
                    end
                    1:
                    begin
                        send_idle_pct = 73;
                        stall_pct = 0;
                    end
                    2:
                    begin
                        wait_for_results();
                        send_idle_pct = 0;
                        stall_pct = 73;
                    end
                    default:
                    begin
                        send_idle_pct = 12;
                        stall_pct = 12;
                    end
                endcase
            end
            sel = $urandom_range(0, 99);
            it = mk_item(ACT_EXEC, $urandom, 8'($urandom_range(0, 255)), random_value(),
                         ($urandom_range(0, 15) == 0));
            rs = 5'($urandom);
            rt = ($urandom_range(0, 1) == 0) ? rs : 5'($urandom);
            rd = 5'($urandom);
            if (sel < 10)
                it.action = ACT_WR_REG;
            else if (sel < 15)
                it.action = ACT_WR_MEM;
            else if (sel < 20)
                it.action = ACT_RD_REG;
            else if (sel < 25)
                it.action = ACT_RD_MEM;
            else if (sel < 28)
                it.action = 3'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_CODE));
            else if (sel >= 34)
            begin
                case ($urandom_range(0, 7))
                    0: it.instruction = enc_r(rs, rt, rd, FN_ADD) | ($urandom & SHAMT_MASK);
                    1: it.instruction = enc_r(rs, rt, rd, FN_SUB) | ($urandom & SHAMT_MASK);
                    2: it.instruction = enc_r(rs, rt, rd, FN_SLT) | ($urandom & SHAMT_MASK);
                    3: it.instruction = enc_i(OP_ADDI, rs, rt, 16'($urandom));
                    4: it.instruction = enc_i(OP_BEQ, rs, rt, 16'($urandom));
                    5: it.instruction = enc_i(OP_BNE, rs, rt, 16'($urandom));
                    default:
                    begin
                        op = ($urandom_range(0, 1) == 0) ? OP_LW : OP_SW;
                        send_memory_op(op, rs, 5'($urandom), it.squash);
                        continue;
                    end
                endcase
            end
            send_item(it, 1'b0, '0);
        end

        wait_for_results();
        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
